[rtl/uue_pkg.sv]
// uue_pkg: shared types, constants and helpers for the uuencode stream encoder
// no dependencies; imported by every rtl module of the block

package uue_pkg;

  localparam int LINE_BYTES_DEF  = 45;
  localparam int LENGTH_BITS_DEF = 24;

  // configuration register file
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMING = 1'b1;

  localparam logic [7:0] CHAR_GRAVE = 8'h60;
  localparam logic [7:0] CHAR_NL    = 8'h0a;

  // output slots of one job, in emission order
  localparam int NUM_SLOTS = 19;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] SL_BEGIN0 = 5'd0;
  localparam logic [SLOT_W-1:0] SL_BEGIN1 = 5'd1;
  localparam logic [SLOT_W-1:0] SL_BEGIN2 = 5'd2;
  localparam logic [SLOT_W-1:0] SL_BEGIN3 = 5'd3;
  localparam logic [SLOT_W-1:0] SL_BEGIN4 = 5'd4;
  localparam logic [SLOT_W-1:0] SL_BEGIN5 = 5'd5;
  localparam logic [SLOT_W-1:0] SL_COUNT  = 5'd6;
  localparam logic [SLOT_W-1:0] SL_DATA0  = 5'd7;
  localparam logic [SLOT_W-1:0] SL_DATA1  = 5'd8;
  localparam logic [SLOT_W-1:0] SL_PAD0   = 5'd9;
  localparam logic [SLOT_W-1:0] SL_PAD1   = 5'd10;
  localparam logic [SLOT_W-1:0] SL_PAD2   = 5'd11;
  localparam logic [SLOT_W-1:0] SL_EOL    = 5'd12;
  localparam logic [SLOT_W-1:0] SL_EOM0   = 5'd13;
  localparam logic [SLOT_W-1:0] SL_EOM1   = 5'd14;
  localparam logic [SLOT_W-1:0] SL_END0   = 5'd15;
  localparam logic [SLOT_W-1:0] SL_END1   = 5'd16;
  localparam logic [SLOT_W-1:0] SL_END2   = 5'd17;
  localparam logic [SLOT_W-1:0] SL_END3   = 5'd18;

  localparam logic [1:0] PAD_NONE  = 2'd0;
  localparam logic [1:0] PAD_TWO   = 2'd2;
  localparam logic [1:0] PAD_THREE = 2'd3;

  localparam int JOB_Q_DEPTH = 2;

  // everything one input byte causes, already encoded
  typedef struct packed {
    logic       begin_txt;
    logic       cnt_vld;
    logic [7:0] cnt_char;
    logic [7:0] d0_char;
    logic       d1_vld;
    logic [7:0] d1_char;
    logic [1:0] pad_cnt;
    logic [7:0] pad_char;
    logic       eol;
    logic       eom;
    logic       end_txt;
  } job_t;

  function automatic logic [7:0] enc6(input logic [5:0] v);
    return (v == 6'd0) ? CHAR_GRAVE : ({2'b00, v} + 8'h20);
  endfunction

endpackage

[rtl/uue_front.sv]
// uue_front: accepts message bytes, tracks message/line/group position and
// builds one encoded job per byte; depends on uue_pkg

module uue_front import uue_pkg::*; #(
  parameter int LINE_BYTES  = LINE_BYTES_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic [CFG_DATA_W-1:0] msg_len,
  input  logic                  framing,
  input  logic                  q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  localparam int LW = $clog2(LINE_BYTES + 1);

  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [LW-1:0]          line_left_r, line_left_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [5:0]             held_r, held_nxt;
  logic                   in_msg_r, in_msg_nxt;

  logic [CFG_DATA_W+LENGTH_BITS-1:0] len_ext;
  logic [LENGTH_BITS-1:0] len_w, bl0, bl2;
  logic [LW-1:0]          ll0, ll1, ll2, n;
  logic [1:0]             ph0, ph1, ph2;
  logic [5:0]             held0, held1, held2, v0, v1;
  logic                   start, new_line, eol, eom;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    len_ext = {LENGTH_BITS'(0), msg_len};
    len_w   = len_ext[LENGTH_BITS-1:0];
    start   = !in_msg_r;

    // a zero length runs as a one-byte message
    bl0   = start ? ((len_w == '0) ? LENGTH_BITS'(1) : len_w) : bytes_left_r;
    ll0   = start ? '0 : line_left_r;
    ph0   = start ? 2'd0 : phase_r;
    held0 = start ? 6'd0 : held_r;

    new_line = (ll0 == '0);
    n = (bl0 > LENGTH_BITS'(LINE_BYTES)) ? LW'(LINE_BYTES) : bl0[LW-1:0];
    ll1   = new_line ? n : ll0;
    ph1   = new_line ? 2'd0 : ph0;
    held1 = new_line ? 6'd0 : held0;

    v1 = in_data_byte[5:0];
    case (ph1)
      2'd0: begin
        v0    = in_data_byte[7:2];
        held2 = {in_data_byte[1:0], 4'b0000};
        ph2   = 2'd1;
      end
      2'd1: begin
        v0    = held1 | {2'b00, in_data_byte[7:4]};
        held2 = {in_data_byte[3:0], 2'b00};
        ph2   = 2'd2;
      end
      default: begin
        v0    = held1 | {4'b0000, in_data_byte[7:6]};
        held2 = 6'd0;
        ph2   = 2'd0;
      end
    endcase

    bl2 = bl0 - LENGTH_BITS'(1);
    ll2 = ll1 - LW'(1);
    eom = (bl2 == '0);
    eol = (ll2 == '0) || eom;

    q_job.begin_txt = start && framing;
    q_job.cnt_vld   = new_line;
    q_job.cnt_char  = enc6(6'(n));
    q_job.d0_char   = enc6(v0);
    q_job.d1_vld    = (ph1 == 2'd2);
    q_job.d1_char   = enc6(v1);
    q_job.pad_char  = enc6(held2);
    if (!eol) begin
      q_job.pad_cnt = PAD_NONE;
    end else if (ph2 == 2'd1) begin
      q_job.pad_cnt = PAD_THREE;
    end else if (ph2 == 2'd2) begin
      q_job.pad_cnt = PAD_TWO;
    end else begin
      q_job.pad_cnt = PAD_NONE;
    end
    q_job.eol     = eol;
    q_job.eom     = eom;
    q_job.end_txt = eom && framing;

    bytes_left_nxt = bytes_left_r;
    line_left_nxt  = line_left_r;
    phase_nxt      = phase_r;
    held_nxt       = held_r;
    in_msg_nxt     = in_msg_r;
    if (q_push) begin
      bytes_left_nxt = bl2;
      line_left_nxt  = eol ? '0 : ll2;
      phase_nxt      = eol ? 2'd0 : ph2;
      held_nxt       = eol ? 6'd0 : held2;
      in_msg_nxt     = !eom;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      line_left_r  <= '0;
      phase_r      <= 2'd0;
      held_r       <= 6'd0;
      in_msg_r     <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      line_left_r  <= line_left_nxt;
      phase_r      <= phase_nxt;
      held_r       <= held_nxt;
      in_msg_r     <= in_msg_nxt;
    end
  end

endmodule

[rtl/uue_job_fifo.sv]
// uue_job_fifo: short queue of encoded jobs between front and back
// depends on uue_pkg for job_t and the queue depth

module uue_job_fifo import uue_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_vld,
  output job_t head_job
);

  localparam int PW = $clog2(JOB_Q_DEPTH);
  localparam int CW = $clog2(JOB_Q_DEPTH + 1);

  job_t          mem_r [JOB_Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(JOB_Q_DEPTH));
  assign head_vld = (count_r != '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/uue_back.sv]
// uue_back: walks the slots of each queued job and sends one character per cycle
// while out_ready is high, through a registered output stage; depends on uue_pkg

module uue_back import uue_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_vld,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  output logic       out_message_done
);

  function automatic logic [NUM_SLOTS-1:0] slot_mask(input job_t j);
    logic [NUM_SLOTS-1:0] m;
    m = '0;
    m[SL_BEGIN0] = j.begin_txt;
    m[SL_BEGIN1] = j.begin_txt;
    m[SL_BEGIN2] = j.begin_txt;
    m[SL_BEGIN3] = j.begin_txt;
    m[SL_BEGIN4] = j.begin_txt;
    m[SL_BEGIN5] = j.begin_txt;
    m[SL_COUNT]  = j.cnt_vld;
    m[SL_DATA0]  = 1'b1;
    m[SL_DATA1]  = j.d1_vld;
    m[SL_PAD0]   = (j.pad_cnt != PAD_NONE);
    m[SL_PAD1]   = (j.pad_cnt != PAD_NONE);
    m[SL_PAD2]   = (j.pad_cnt == PAD_THREE);
    m[SL_EOL]    = j.eol;
    m[SL_EOM0]   = j.eom;
    m[SL_EOM1]   = j.eom;
    m[SL_END0]   = j.end_txt;
    m[SL_END1]   = j.end_txt;
    m[SL_END2]   = j.end_txt;
    m[SL_END3]   = j.end_txt;
    return m;
  endfunction

  function automatic logic [SLOT_W-1:0] first_slot(input logic [NUM_SLOTS-1:0] m);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = SLOT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] slot_char(input job_t j, input logic [SLOT_W-1:0] s);
    case (s)
      SL_BEGIN0: return 8'h62;  // b
      SL_BEGIN1: return 8'h65;  // e
      SL_BEGIN2: return 8'h67;  // g
      SL_BEGIN3: return 8'h69;  // i
      SL_BEGIN4: return 8'h6e;  // n
      SL_BEGIN5: return CHAR_NL;
      SL_COUNT:  return j.cnt_char;
      SL_DATA0:  return j.d0_char;
      SL_DATA1:  return j.d1_char;
      SL_PAD0:   return j.pad_char;
      SL_PAD1:   return CHAR_GRAVE;
      SL_PAD2:   return CHAR_GRAVE;
      SL_EOL:    return CHAR_NL;
      SL_EOM0:   return CHAR_GRAVE;
      SL_EOM1:   return CHAR_NL;
      SL_END0:   return 8'h65;  // e
      SL_END1:   return 8'h6e;  // n
      SL_END2:   return 8'h64;  // d
      SL_END3:   return CHAR_NL;
      default:   return CHAR_NL;
    endcase
  endfunction

  job_t              job_r, job_nxt;
  logic              busy_r, busy_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              ovld_r, ovld_nxt;
  logic [7:0]        ochar_r, ochar_nxt;
  logic              olast_r, olast_nxt;
  logic              odone_r, odone_nxt;

  logic [NUM_SLOTS-1:0] cur_mask, rem_mask;
  logic                 has_next, adv;

  assign out_valid        = ovld_r;
  assign out_char         = ochar_r;
  assign out_last_of_run  = olast_r;
  assign out_message_done = odone_r;

  always_comb begin
    cur_mask = slot_mask(job_r);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rem_mask[i] = cur_mask[i] && (SLOT_W'(i) > slot_r);
    end
    has_next = |rem_mask;
    adv      = busy_r && (!ovld_r || out_ready);

    job_nxt   = job_r;
    busy_nxt  = busy_r;
    slot_nxt  = slot_r;
    ovld_nxt  = ovld_r && !out_ready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    q_pop     = 1'b0;

    if (adv) begin
      ovld_nxt  = 1'b1;
      ochar_nxt = slot_char(job_r, slot_r);
      olast_nxt = !has_next;
      odone_nxt = !has_next && job_r.eom;
      if (has_next) begin
        slot_nxt = first_slot(rem_mask);
      end else begin
        // chain straight into the next job without a bubble
        busy_nxt = q_vld;
        q_pop    = q_vld;
        job_nxt  = q_job;
        slot_nxt = first_slot(slot_mask(q_job));
      end
    end else if (!busy_r && q_vld) begin
      busy_nxt = 1'b1;
      q_pop    = 1'b1;
      job_nxt  = q_job;
      slot_nxt = first_slot(slot_mask(q_job));
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
      ovld_r <= ovld_nxt;
    end
  end

endmodule

[rtl/uuencode_stream_encoder.sv]
// uuencode_stream_encoder: top level, configuration registers and wiring
// depends on uue_pkg, uue_front, uue_job_fifo and uue_back
//
// usage:
//   set message_length (index 0) and framing_mode (index 1) through the cfg_
//   write port while the block is idle, then send the message bytes on the
//   in_ valid/ready channel. encoded characters leave on the out_ channel, one
//   per transfer, with out_last_of_run on the last character caused by each
//   byte and out_message_done on the final character of the message.
//   a byte accepted into an idle block passes the job queue, the back's job
//   register and the output register before its first character shows. the
//   output stage moves one character per cycle while out_ready is high; a
//   byte causes 1 to 18 characters (group characters, plus line count, padding,
//   newline and begin/end text when they fall on that byte). the front takes
//   one byte per cycle while the two-entry job queue has room.
//   reset: position state clears, message_length becomes 1 and
//   framing_mode 0; no clearing pass.
//   stall: when out_ready is low the output register holds, the queue fills
//   and in_ready drops until the receiver takes characters again.

module uuencode_stream_encoder import uue_pkg::*; #(
  parameter int LINE_BYTES  = LINE_BYTES_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_last_of_run,
  output logic                  out_message_done
);

  logic [CFG_DATA_W-1:0] msg_len_r, msg_len_nxt;
  logic                  framing_r, framing_nxt;

  logic q_full, q_push, q_pop, q_vld;
  job_t push_job, head_job;

  always_comb begin
    msg_len_nxt = msg_len_r;
    framing_nxt = framing_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MSG_LEN: msg_len_nxt = cfg_wdata;
        CFG_FRAMING: framing_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r <= CFG_DATA_W'(1);
      framing_r <= 1'b0;
    end else begin
      msg_len_r <= msg_len_nxt;
      framing_r <= framing_nxt;
    end
  end

  uue_front #(
    .LINE_BYTES  (LINE_BYTES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .msg_len      (msg_len_r),
    .framing      (framing_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  uue_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .head_vld (q_vld),
    .head_job (head_job)
  );

  uue_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_vld            (q_vld),
    .q_job            (head_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_last_of_run  (out_last_of_run),
    .out_message_done (out_message_done)
  );

endmodule
